// ===== hdl/pe_task_slot_table_defines.svh =====
// Assertion macros used by the checker file
`ifndef PE_TASK_SLOT_TABLE_DEFINES_SVH
`define PE_TASK_SLOT_TABLE_DEFINES_SVH

// Implication checked at every clock edge outside reset
`define PTST_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked at the clock edge after the antecedent
`define PTST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ptst_pkg.sv =====
package ptst_pkg;

  typedef enum logic [2:0] {
    REQ_ADD_PROC = 3'd0,
    REQ_ADD_TASK = 3'd1,
    REQ_REM_TASK = 3'd2,
    REQ_SET_UTIL = 3'd3,
    REQ_SLACK    = 3'd4,
    REQ_QUERY    = 3'd5,
    REQ_PICK     = 3'd6,
    REQ_NOP      = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_PROC_MISSING = 3'd1,
    ST_TABLE_FULL   = 3'd2,
    ST_NO_PAGE      = 3'd3,
    ST_DUPLICATE    = 3'd4,
    ST_TASK_MISSING = 3'd5,
    ST_ALL_FREE     = 3'd6
  } status_t;

  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [23:0] SAMPLES_MAX = 24'hFF_FFFF;
  localparam int DATA_IN_W = 48;
  localparam int DATA_OUT_W = 80;

  // Result of one request
  typedef struct packed {
    logic [6:0]  task_util;
    logic [15:0] be_task_id;
    logic        be_found;
    logic [6:0]  avg_slack;
    logic [2:0]  free_slots;
    logic [2:0]  rt_count;
    logic [8:0]  proc_util;
    logic [15:0] pe_address;
    logic        pe_found;
    logic [2:0]  status;
  } result_t;

  // Divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [23:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_CHK, S_FREE_RD, S_FREE_CHK,
    S_SLOT_RD, S_SLOT_CHK, S_WRITE, S_DIV, S_DIV_WAIT, S_DONE,
    S_PICK_RD, S_PICK_CHK
  } fsm_t;

endpackage

// ===== hdl/ptst_div.sv =====
module ptst_div
  import ptst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        busy,
  output logic [6:0]  quot
);
  // Restoring divider, one quotient bit per cycle; result fits in 7 bits
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] q_r, q_nxt;
  logic [23:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [55:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    trial   = '0;
    if (req.start) begin
      rem_nxt = '0;
      q_nxt   = req.dividend;
      den_nxt = req.divisor;
      cnt_nxt = 6'd32;
    end else if (cnt_r != 6'd0) begin
      trial = {24'd0, rem_r[30:0], q_r[31]} - {32'd0, den_r};
      if (!trial[55]) begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], q_r[31]};
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign busy = (cnt_r != 6'd0);
  assign quot = q_r[6:0];
endmodule

// ===== hdl/pe_task_slot_table.sv =====
// Processor / task slot table.
// Input channel in_*: one request per item; tdata holds req_type, proc_xy,
// task_id, percent. Output channel out_*: exactly one result per request.
// Each request runs through a sequencer over two synchronous memories: a
// processor table (one row per processor) and a slot table (one row per
// processor holding all its slots), both with registered reads.
// Sequence: lookups walk the processor table, reading and then checking
// each entry in turn. Task, slack and query requests do a lookup, a pick
// scans every entry, and adding a processor takes one more pass over the
// valid bits; a query with slack samples also runs the bit-serial divider.
// One request is in flight at a time; the next request can be taken the
// cycle after the result is.
// The result is held in an output register; a new request is taken only
// after the previous result has been delivered.
// Reset: valid bits for processors and slots live in flip-flops and clear at
// once; no clearing pass is needed. Stored counts of an entry are cleared
// when a processor is added.
// Receiver stall: the result holds on out_tdata until out_tready is high.
module pe_task_slot_table
  import ptst_pkg::*;
#(
  parameter int NUM_PROCS  = 16,
  parameter int TASK_SLOTS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // req_type[2:0], proc_xy[18:3], task_id[34:19], percent[41:35]
  input  logic [DATA_IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[2:0], pe_found[3], pe_address[19:4], proc_util[28:20],
  // rt_count[31:29], free_slots[34:32], avg_slack[41:35], be_found[42],
  // be_task_id[58:43], task_util[65:59]
  output logic [DATA_OUT_W-1:0] out_tdata
);
  localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int FW = $clog2(TASK_SLOTS + 1);
  localparam int PEW = 16 + FW + 32 + 24;

  // processor row: addr, free count, slack sum, sample count
  logic [PEW-1:0] pmem [NUM_PROCS];
  logic [TASK_SLOTS*16-1:0] tmem [NUM_PROCS];
  logic [TASK_SLOTS*7-1:0]  umem [NUM_PROCS];
  logic [NUM_PROCS-1:0]  pvalid_r;
  logic [TASK_SLOTS-1:0] svalid_r [NUM_PROCS];

  logic [PW-1:0] rd_idx;
  logic [PEW-1:0] prow_r;
  logic [TASK_SLOTS*16-1:0] trow_r;
  logic [TASK_SLOTS*7-1:0]  urow_r;
  logic p_we, s_we;
  logic [PEW-1:0] p_wd;
  logic [TASK_SLOTS*16-1:0] t_wd;
  logic [TASK_SLOTS*7-1:0]  u_wd;
  logic [TASK_SLOTS-1:0] sv_wd;
  logic pv_set;

  fsm_t st_r, st_nxt;
  req_t req_r, req_nxt;
  logic [15:0] addr_r, addr_nxt, tid_r, tid_nxt;
  logic [6:0] pct_r, pct_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [FW-1:0] bestf_r, bestf_nxt;
  logic found_r, found_nxt;
  logic [15:0] bestaddr_r, bestaddr_nxt;
  result_t res_r, res_nxt;
  logic ovalid_r, ovalid_nxt;
  div_req_t dreq;
  logic dbusy;
  logic [6:0] dquot;

  always_ff @(posedge clk) begin
    prow_r <= pmem[rd_idx];
    trow_r <= tmem[rd_idx];
    urow_r <= umem[rd_idx];
    if (p_we) pmem[idx_r] <= p_wd;
    if (s_we) begin
      tmem[idx_r] <= t_wd;
      umem[idx_r] <= u_wd;
    end
  end

  ptst_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quot(dquot));

  // fields of the registered row
  logic [15:0] r_addr;
  logic [FW-1:0] r_free;
  logic [31:0] r_sum;
  logic [23:0] r_cnt;
  assign {r_cnt, r_sum, r_free, r_addr} = prow_r;
  logic [TASK_SLOTS-1:0] sv_cur;
  assign sv_cur = svalid_r[idx_r];

  // slot scan over the registered row
  logic [TASK_SLOTS-1:0] match;
  logic tmatch, hasrt, befound, hasfree;
  logic [SW-1:0] mslot, lastfree;
  logic [15:0] betid;
  logic [8:0] usum;
  logic [2:0] rtc;
  logic [6:0] mutil;
  always_comb begin
    tmatch = 1'b0; mslot = '0; hasrt = 1'b0; befound = 1'b0; betid = '0;
    usum = '0; rtc = '0; mutil = '0; hasfree = 1'b0; lastfree = '0;
    for (int s = 0; s < TASK_SLOTS; s++) begin
      match[s] = sv_cur[s] && (trow_r[s*16 +: 16] == tid_r);
      if (match[s] && !tmatch) begin
        tmatch = 1'b1; mslot = SW'(s); mutil = urow_r[s*7 +: 7];
      end
      if (!sv_cur[s]) begin
        hasfree = 1'b1; lastfree = SW'(s);
      end else if (urow_r[s*7 +: 7] != 7'd0) begin
        hasrt = 1'b1;
        if (usum + 9'(urow_r[s*7 +: 7]) > 9'd511 || usum > 9'd511 - 9'(urow_r[s*7 +: 7]))
          usum = 9'd511;
        else
          usum = usum + 9'(urow_r[s*7 +: 7]);
        if (rtc != 3'd7) rtc = rtc + 3'd1;
      end else if (!befound) begin
        befound = 1'b1; betid = trow_r[s*16 +: 16];
      end
    end
  end

  logic [2:0] free_sat;
  assign free_sat = (32'(r_free) > 7) ? 3'd7 : 3'(r_free);

  // sequencer
  always_comb begin
    st_nxt = st_r; req_nxt = req_r; addr_nxt = addr_r; tid_nxt = tid_r;
    pct_nxt = pct_r; idx_nxt = idx_r; bestf_nxt = bestf_r;
    found_nxt = found_r; bestaddr_nxt = bestaddr_r;
    res_nxt = res_r; ovalid_nxt = ovalid_r;
    rd_idx = idx_r; p_we = 1'b0; s_we = 1'b0; pv_set = 1'b0;
    p_wd = prow_r; t_wd = trow_r; u_wd = urow_r; sv_wd = sv_cur;
    dreq = '0;
    in_tready = (st_r == S_IDLE) && !ovalid_r;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          req_nxt = req_t'(in_tdata[2:0]);
          addr_nxt = in_tdata[18:3];
          tid_nxt = in_tdata[34:19];
          pct_nxt = (in_tdata[41:35] > PCT_MAX) ? PCT_MAX : in_tdata[41:35];
          idx_nxt = '0; found_nxt = 1'b0; res_nxt = '0;
          st_nxt = (req_t'(in_tdata[2:0]) == REQ_NOP) ? S_DONE
                 : (req_t'(in_tdata[2:0]) == REQ_PICK) ? S_PICK_RD : S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        rd_idx = idx_r; st_nxt = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (pvalid_r[idx_r] && r_addr == addr_r) begin
          if (req_r == REQ_ADD_PROC) begin
            res_nxt.status = ST_DUPLICATE; st_nxt = S_DONE;
          end else begin
            st_nxt = S_SLOT_CHK;
          end
        end else if (32'(idx_r) == NUM_PROCS - 1) begin
          if (req_r == REQ_ADD_PROC) begin
            idx_nxt = '0; st_nxt = S_FREE_CHK;
          end else begin
            res_nxt.status = ST_PROC_MISSING; st_nxt = S_DONE;
          end
        end else begin
          idx_nxt = idx_r + PW'(1); st_nxt = S_FIND_RD;
        end
      end
      S_FREE_CHK: begin
        if (!pvalid_r[idx_r]) begin
          st_nxt = S_WRITE;
        end else if (32'(idx_r) == NUM_PROCS - 1) begin
          res_nxt.status = ST_TABLE_FULL; st_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + PW'(1);
        end
      end
      S_SLOT_CHK: begin
        st_nxt = S_DONE;
        priority case (req_r)
          REQ_ADD_TASK: begin
            if (r_free == '0) res_nxt.status = ST_NO_PAGE;
            else if (tmatch) res_nxt.status = ST_DUPLICATE;
            else if (!hasfree) res_nxt.status = ST_TABLE_FULL;
            else st_nxt = S_WRITE;
          end
          REQ_REM_TASK: begin
            if (32'(r_free) >= TASK_SLOTS) res_nxt.status = ST_ALL_FREE;
            else if (!tmatch) res_nxt.status = ST_TASK_MISSING;
            else st_nxt = S_WRITE;
          end
          REQ_SET_UTIL, REQ_SLACK: st_nxt = S_WRITE;
          REQ_QUERY: begin
            res_nxt.proc_util = usum; res_nxt.rt_count = rtc;
            res_nxt.free_slots = free_sat; res_nxt.be_found = befound;
            res_nxt.be_task_id = betid;
            res_nxt.task_util = tmatch ? mutil : 7'd0;
            res_nxt.status = tmatch ? ST_OK : ST_TASK_MISSING;
            if (r_cnt == '0) begin
              res_nxt.avg_slack = PCT_MAX;
            end else begin
              dreq.start = 1'b1; dreq.dividend = r_sum; dreq.divisor = r_cnt;
              st_nxt = S_DIV;
            end
          end
          default: ;
        endcase
      end
      S_WRITE: begin
        st_nxt = S_DONE;
        unique case (req_r)
          REQ_ADD_PROC: begin
            p_we = 1'b1; pv_set = 1'b1; sv_wd = '0;
            p_wd = {24'd0, 32'd0, FW'(TASK_SLOTS), addr_r};
          end
          REQ_ADD_TASK: begin
            p_we = 1'b1; s_we = 1'b1;
            p_wd = {r_cnt, r_sum, r_free - FW'(1), r_addr};
            t_wd[lastfree*16 +: 16] = tid_r; u_wd[lastfree*7 +: 7] = '0;
            sv_wd[lastfree] = 1'b1;
          end
          REQ_REM_TASK: begin
            p_we = 1'b1; s_we = 1'b1;
            p_wd = {r_cnt, r_sum, r_free + FW'(1), r_addr};
            u_wd[mslot*7 +: 7] = '0; sv_wd[mslot] = 1'b0;
          end
          REQ_SET_UTIL: begin
            s_we = 1'b1;
            for (int s = 0; s < TASK_SLOTS; s++)
              if (match[s]) u_wd[s*7 +: 7] = pct_r;
          end
          REQ_SLACK: begin
            p_we = (r_cnt < SAMPLES_MAX);
            p_wd = {r_cnt + 24'd1, r_sum + 32'(pct_r), r_free, r_addr};
          end
          default: ;
        endcase
      end
      S_DIV: st_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (!dbusy) begin
          res_nxt.avg_slack = dquot; st_nxt = S_DONE;
        end
      end
      S_PICK_RD: begin
        rd_idx = idx_r; st_nxt = S_PICK_CHK;
      end
      S_PICK_CHK: begin
        if (pvalid_r[idx_r] && r_free != '0 && !hasrt &&
            (!found_r || bestf_r > r_free)) begin
          found_nxt = 1'b1; bestf_nxt = r_free;
          bestaddr_nxt = r_addr;
        end
        if (32'(idx_r) == NUM_PROCS - 1) begin
          st_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + PW'(1); st_nxt = S_PICK_RD;
        end
      end
      S_DONE: begin
        if (req_r == REQ_PICK) begin
          res_nxt.pe_found = found_r;
          res_nxt.pe_address = found_r ? bestaddr_r : 16'd0;
        end
        ovalid_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    // FREE_CHK reads flip-flop valid bits only
    if (st_r == S_FREE_RD) st_nxt = S_FREE_CHK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ovalid_r <= 1'b0; pvalid_r <= '0;
      for (int p = 0; p < NUM_PROCS; p++) svalid_r[p] <= '0;
    end else begin
      st_r <= st_nxt; ovalid_r <= ovalid_nxt;
      if (pv_set) pvalid_r[idx_r] <= 1'b1;
      if (pv_set || s_we) svalid_r[idx_r] <= sv_wd;
    end
    req_r <= req_nxt; addr_r <= addr_nxt; tid_r <= tid_nxt; pct_r <= pct_nxt;
    idx_r <= idx_nxt; bestf_r <= bestf_nxt;
    found_r <= found_nxt; bestaddr_r <= bestaddr_nxt; res_r <= res_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {14'd0, res_r};
endmodule

// ===== hdl/ptst_checker.sv =====
`include "pe_task_slot_table_defines.svh"
module ptst_checker
  import ptst_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [DATA_OUT_W-1:0] out_tdata
);
  // no new request while a result is pending
  `PTST_ASSERT(a_no_overlap, clk, rst_n, out_tvalid, !in_tready, "request taken with result pending")
  // a request is never answered in the cycle after it is taken
  `PTST_ASSERT_NEXT(a_lat, clk, rst_n, in_tvalid && in_tready, !out_tvalid, "result too early")
  // result held while stalled
  `PTST_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  // pe_found only together with ok status
  `PTST_ASSERT(a_pick, clk, rst_n, out_tvalid && out_tdata[3], out_tdata[2:0] == ST_OK, "pick with error")
endmodule

bind pe_task_slot_table ptst_checker u_ptst_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
